FILE: rtl/cvc_pkg.sv
// ----------------------------------------------------------------------------
// cvc_pkg
// Shared types, constants and helper functions of the chained Caesar /
// Vigenere character cipher core.
// ----------------------------------------------------------------------------
package cvc_pkg;

    // key storage
    localparam int MAX_KEY_CHARS = 16;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_CHARS);
    localparam int KEY_LEN_W     = 5;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_L1_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_L1_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_L2_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 3'd6;

    // layer 1 modes
    localparam logic [1:0] L1_OFF   = 2'd0;
    localparam logic [1:0] L1_ROT13 = 2'd1;
    localparam logic [1:0] L1_KEYED = 2'd2;

    // alphabet constants
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7A;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_Z = 8'h5A;
    localparam logic [4:0] ALPHA_LEN = 5'd26;
    localparam logic [4:0] ROT_SHIFT = 5'd13;

    // configuration register set
    typedef struct packed {
        logic [1:0]            l1_mode;
        logic [4:0]            l1_shift;
        logic                  l2_enable;
        logic                  decrypt;
        logic [CFG_DATA_W-1:0] key_low;
        logic [CFG_DATA_W-1:0] key_high;
        logic [KEY_LEN_W-1:0]  key_len;
    } t_cfg;

    // per-character shift decision handed to the datapath
    typedef struct packed {
        logic                 is_letter;
        logic                 is_upper;
        logic [4:0]           offset;
        logic [4:0]           shift;
        logic [KEY_IDX_W-1:0] next_index;
    } t_shift_info;

    // letter class of a byte: {is_letter, is_upper, offset 0..25}
    function automatic logic [6:0] letter_class(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
                d = c - CHAR_LC_A;
                letter_class = {1'b1, 1'b0, d[4:0]};
            end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
                d = c - CHAR_UC_A;
                letter_class = {1'b1, 1'b1, d[4:0]};
            end else begin
                letter_class = {2'b00, d[4:0]};
            end
        end
    endfunction

    // reduce a value below 52 into 0..25
    function automatic logic [4:0] mod_alpha(input logic [5:0] v);
        logic [5:0] t;
        begin
            t = v - {1'b0, ALPHA_LEN};
            mod_alpha = (v >= {1'b0, ALPHA_LEN}) ? t[4:0] : v[4:0];
        end
    endfunction

endpackage

FILE: rtl/cvc_in_if.sv
// ----------------------------------------------------------------------------
// cvc_in_if
// Character input channel: valid/ready handshake with message byte and flags.
// ----------------------------------------------------------------------------
interface cvc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       start_of_message;
    logic       last_in;

    modport source (output valid, output char_in, output start_of_message,
                    output last_in, input ready);
    modport sink   (input valid, input char_in, input start_of_message,
                    input last_in, output ready);
endinterface

FILE: rtl/cvc_out_if.sv
// ----------------------------------------------------------------------------
// cvc_out_if
// Character result channel: valid/ready handshake with transformed byte.
// ----------------------------------------------------------------------------
interface cvc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_out;

    modport source (output valid, output char_out, output last_out, input ready);
    modport sink   (input valid, input char_out, input last_out, output ready);
endinterface

FILE: rtl/cvc_cfg_if.sv
// ----------------------------------------------------------------------------
// cvc_cfg_if
// Configuration write channel: valid/ready handshake with index and data.
// ----------------------------------------------------------------------------
interface cvc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cvc_pkg::CFG_IDX_W-1:0]  index;
    logic [cvc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cvc_shift_sel.sv
// ----------------------------------------------------------------------------
// cvc_shift_sel
// Per-character shift selection: classifies the message byte, looks up the
// key character, forms the combined modulo-26 shift and the next key position.
// ----------------------------------------------------------------------------
module cvc_shift_sel (
    input  logic [7:0]                    i_char,
    input  logic [cvc_pkg::KEY_IDX_W-1:0] i_key_index,
    input  cvc_pkg::t_cfg                 i_cfg,
    output cvc_pkg::t_shift_info          o_info
);
    import cvc_pkg::*;

    logic [6:0]             msg_class;
    logic [6:0]             key_class;
    logic [7:0]             key_byte;
    logic [2*CFG_DATA_W-1:0] key_all;
    logic [4:0]             l1_shift;
    logic [4:0]             sum_shift;
    logic [4:0]             enc_shift;
    logic [4:0]             dec_shift;
    logic [KEY_LEN_W-1:0]   eff_len;
    logic [KEY_LEN_W-1:0]   idx_inc;
    logic [KEY_IDX_W-1:0]   next_index;
    logic                   advance;

    // message and key character classes
    assign msg_class = letter_class(i_char);
    assign key_all   = {i_cfg.key_high, i_cfg.key_low};
    assign key_byte  = key_all[{i_key_index, 3'b000} +: 8];
    assign key_class = letter_class(key_byte);

    // layer 1 shift
    always_comb begin
        case (i_cfg.l1_mode)
            L1_ROT13: l1_shift = ROT_SHIFT;
            L1_KEYED: l1_shift = mod_alpha({1'b0, i_cfg.l1_shift});
            default:  l1_shift = 5'd0;
        endcase
    end

    // layer 2 keyword shift, applied only for letter key characters
    assign advance   = msg_class[6] & i_cfg.l2_enable & key_class[6];
    assign sum_shift = advance ? mod_alpha({1'b0, l1_shift} + {1'b0, key_class[4:0]})
                               : l1_shift;
    assign dec_shift = (sum_shift == 5'd0) ? 5'd0 : (ALPHA_LEN - sum_shift);
    assign enc_shift = i_cfg.decrypt ? dec_shift : sum_shift;

    // key length clamped to 1..MAX_KEY_CHARS, wrap on the last position
    always_comb begin
        if (i_cfg.key_len == '0) begin
            eff_len = KEY_LEN_W'(1);
        end else if (i_cfg.key_len > KEY_LEN_W'(MAX_KEY_CHARS)) begin
            eff_len = KEY_LEN_W'(MAX_KEY_CHARS);
        end else begin
            eff_len = i_cfg.key_len;
        end
    end

    assign idx_inc = {{(KEY_LEN_W-KEY_IDX_W){1'b0}}, i_key_index} + KEY_LEN_W'(1);

    always_comb begin
        if (!advance) begin
            next_index = i_key_index;
        end else if (idx_inc >= eff_len) begin
            next_index = '0;
        end else begin
            next_index = idx_inc[KEY_IDX_W-1:0];
        end
    end

    // is_letter, is_upper, offset, shift, next_index
    assign o_info = {msg_class[6], msg_class[5], msg_class[4:0], enc_shift, next_index};

endmodule

FILE: rtl/caesar_vigenere_chain_cipher_core.sv
// ----------------------------------------------------------------------------
// caesar_vigenere_chain_cipher_core
// Chained ROT13 / keyed Caesar / Vigenere character cipher, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// The core takes one character per clock and returns one character per clock,
// in order, via stage 1 and the result register, unless the output stalls. The
// shift and the key position are settled in the accept cycle, so consecutive
// characters stream back to back; the rotation itself is done in the second
// register stage. Letters keep their case and non-letters pass unchanged.
// Configuration writes are taken at any time (ready is always high) but should
// only be issued while no characters are in flight.
module caesar_vigenere_chain_cipher_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cvc_in_if.sink    i_in,
    cvc_out_if.source o_out,
    cvc_cfg_if.sink   i_cfg
);
    import cvc_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // key position
    logic [KEY_IDX_W-1:0] r_key_index;
    logic [KEY_IDX_W-1:0] n_key_index;
    logic [KEY_IDX_W-1:0] cur_index;

    // stage 1 (shift decided)
    logic        r_s1_valid;
    logic        r_s1_letter;
    logic        r_s1_upper;
    logic [4:0]  r_s1_offset;
    logic [4:0]  r_s1_shift;
    logic [7:0]  r_s1_char;
    logic        r_s1_last;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;
    logic [7:0]  n_out_char;

    logic        in_acc;
    logic        s1_ready;
    logic        out_load;
    logic [4:0]  rot;
    t_shift_info shift_info;

    // handshake
    assign out_load  = !r_out_valid || o_out.ready;
    assign s1_ready  = !r_s1_valid || out_load;
    assign i_in.ready = s1_ready;
    assign in_acc    = i_in.valid && s1_ready;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.l1_mode   <= L1_OFF;
            r_cfg.l1_shift  <= '0;
            r_cfg.l2_enable <= 1'b0;
            r_cfg.decrypt   <= 1'b0;
            r_cfg.key_low   <= '0;
            r_cfg.key_high  <= '0;
            r_cfg.key_len   <= KEY_LEN_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_L1_MODE:   r_cfg.l1_mode   <= i_cfg.data[1:0];
                REG_L1_SHIFT:  r_cfg.l1_shift  <= i_cfg.data[4:0];
                REG_L2_ENABLE: r_cfg.l2_enable <= i_cfg.data[0];
                REG_DECRYPT:   r_cfg.decrypt   <= i_cfg.data[0];
                REG_KEY_LOW:   r_cfg.key_low   <= i_cfg.data;
                REG_KEY_HIGH:  r_cfg.key_high  <= i_cfg.data;
                REG_KEY_LEN:   r_cfg.key_len   <= i_cfg.data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // shift selection for the incoming character
    assign cur_index = i_in.start_of_message ? '0 : r_key_index;

    cvc_shift_sel u_shift_sel (
        .i_char      (i_in.char_in),
        .i_key_index (cur_index),
        .i_cfg       (r_cfg),
        .o_info      (shift_info)
    );

    assign n_key_index = in_acc ? shift_info.next_index : r_key_index;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_index <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_key_index <= n_key_index;
            if (s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_letter <= shift_info.is_letter;
            r_s1_upper  <= shift_info.is_upper;
            r_s1_offset <= shift_info.offset;
            r_s1_shift  <= shift_info.shift;
            r_s1_char   <= i_in.char_in;
            r_s1_last   <= i_in.last_in;
        end
    end

    // rotation within the letter's case
    assign rot = mod_alpha({1'b0, r_s1_offset} + {1'b0, r_s1_shift});

    always_comb begin
        if (r_s1_letter) begin
            n_out_char = (r_s1_upper ? CHAR_UC_A : CHAR_LC_A) + {3'b000, rot};
        end else begin
            n_out_char = r_s1_char;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_char <= n_out_char;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_out_char;
    assign o_out.last_out = r_out_last;

    // an accepted character always lands in stage 1
    a_s1_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted character missing from stage 1");

    // key position never moves with the keyword layer off, outside a start of message
    a_key_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_cfg.l2_enable && !i_in.start_of_message) |=> $stable(r_key_index))
        else $error("key position moved with keyword layer disabled");

    // start of message on a non-letter leaves the position at zero
    a_key_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.start_of_message && !shift_info.is_letter)
            |=> (r_key_index == '0))
        else $error("key position not cleared at start of message");

endmodule
